// ===== src/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, types and constants of the Euler angle to quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

   localparam int ANGLE_IN_W  = 16;  // Q2.13 input angles
   localparam int QUAT_W      = 16;  // Q1.14 quaternion parts
   localparam int DATA_W      = 32;  // Q1.30 sine / cosine datapath
   localparam int PROD_W      = 64;  // full product width
   localparam int ANG_GUARD   = 3;   // integer and sign bits over the fraction
   localparam int COMB_STAGES = 5;   // register stages of the product network

   typedef logic signed [ANGLE_IN_W-1:0] angle_in_type;
   typedef logic signed [QUAT_W-1:0]     quat_type;
   typedef logic signed [DATA_W-1:0]     data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;

   // CORDIC start value: inverse of the infinite CORDIC gain, Q1.30
   localparam data_type GAIN_Q30 = 32'sd652032874;

   // pi in unsigned Q4.60
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

endpackage

`default_nettype wire

// ===== src/e2q_if.sv =====
// ----------------------------------------------------------------------------
// e2q_if
// Valid/ready channels: request (three angles) and response (quaternion).
// ----------------------------------------------------------------------------
`default_nettype none

interface e2q_req_if;
   logic                  valid;
   logic                  ready;
   e2q_pkg::angle_in_type roll_angle;
   e2q_pkg::angle_in_type pitch_angle;
   e2q_pkg::angle_in_type yaw_angle;

   modport source (output valid, output roll_angle, output pitch_angle,
                   output yaw_angle, input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle,
                   input yaw_angle, output ready);
endinterface

interface e2q_rsp_if;
   logic              valid;
   logic              ready;
   e2q_pkg::quat_type quat_x;
   e2q_pkg::quat_type quat_y;
   e2q_pkg::quat_type quat_z;
   e2q_pkg::quat_type quat_w;

   modport source (output valid, output quat_x, output quat_y, output quat_z,
                   output quat_w, input ready);
   modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                   input quat_w, output ready);
endinterface

`default_nettype wire

// ===== src/euler_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Roll, pitch and yaw (Q2.13 radians) to a ZYX unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
// Fully pipelined: one item per clock while the output is not stalled. From
// acceptance to rsp valid, one stage halves and folds each angle into
// [-pi/2, pi/2], one stage per CORDIC iteration, one stage fixes the cosine
// sign, and five stages form the products, sums and the saturated Q1.14 parts.
// Each of the three angles has its own CORDIC chain; the product network is
// shared by all four parts. Every stage carries a valid bit and loads only
// when it is empty or its item moves on, so bubbles close up under a stall:
// req ready drops only when every stage holds an item and the result in the
// output register is not being taken. Any 16-bit angle is accepted; half
// angles past pi/2 are reflected and the cosine negated, so the full +-4 rad
// range is covered. Parts are saturated to +-1.0 (+-16384). No state besides
// the valid bits; reset clears them.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion #(
   parameter int CORDIC_STEPS = 16,  // 8 to 24
   parameter int ANGLE_BITS   = 16   // 12 to 24 fraction bits of the half angle
) (
   input  wire      clock,
   input  wire      reset,
   e2q_req_if.sink  req_ch,
   e2q_rsp_if.source rsp_ch
);

   localparam int SC_STAGES = CORDIC_STEPS + 2;
   localparam int NSTG      = SC_STAGES + e2q_pkg::COMB_STAGES;
   localparam logic [NSTG-1:0] ALL_ONES = '1;

   logic [NSTG-1:0]   vld_ff, vld_in, stage_en;
   e2q_pkg::data_type cr, sr, cp, sp, cy, sy;

   // stage k may load unless it and every stage after it are full and the
   // output is stalled
   always_comb begin
      for (int k = 0; k < NSTG; k++) begin
         stage_en[k] = rsp_ch.ready | ~(&(vld_ff | ~(ALL_ONES << k)));
      end
   end

   always_comb begin
      vld_in[0] = stage_en[0] ? req_ch.valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = stage_en[0];
   assign rsp_ch.valid = vld_ff[NSTG-1];

   // half-angle sine / cosine, one chain per axis
   e2q_sincos #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_roll (
      .clock    (clock),
      .stage_en (stage_en[SC_STAGES-1:0]),
      .angle_in (req_ch.roll_angle),
      .cos_ff   (cr),
      .sin_ff   (sr)
   );

   e2q_sincos #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_pitch (
      .clock    (clock),
      .stage_en (stage_en[SC_STAGES-1:0]),
      .angle_in (req_ch.pitch_angle),
      .cos_ff   (cp),
      .sin_ff   (sp)
   );

   e2q_sincos #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_yaw (
      .clock    (clock),
      .stage_en (stage_en[SC_STAGES-1:0]),
      .angle_in (req_ch.yaw_angle),
      .cos_ff   (cy),
      .sin_ff   (sy)
   );

   // ZYX product network; its last stage is the output register
   e2q_combine u_combine (
      .clock     (clock),
      .stage_en  (stage_en[NSTG-1:SC_STAGES]),
      .cr        (cr),
      .sr        (sr),
      .cp        (cp),
      .sp        (sp),
      .cy        (cy),
      .sy        (sy),
      .quat_x_ff (rsp_ch.quat_x),
      .quat_y_ff (rsp_ch.quat_y),
      .quat_z_ff (rsp_ch.quat_z),
      .quat_w_ff (rsp_ch.quat_w)
   );

endmodule

`default_nettype wire

// ===== src/e2q_cordic_step.sv =====
// ----------------------------------------------------------------------------
// e2q_cordic_step
// One registered rotation-mode CORDIC iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic_step #(
   parameter int STEP       = 0,
   parameter int ANGLE_BITS = 16
) (
   input  wire                               clock,
   input  wire                               step_en,
   input  wire e2q_pkg::data_type            x_prev,
   input  wire e2q_pkg::data_type            y_prev,
   input  wire logic signed [ANGLE_BITS+e2q_pkg::ANG_GUARD-1:0] h_prev,
   input  wire                               neg_prev,
   output e2q_pkg::data_type                 x_ff,
   output e2q_pkg::data_type                 y_ff,
   output logic signed [ANGLE_BITS+e2q_pkg::ANG_GUARD-1:0]      h_ff,
   output logic                              neg_ff
);

   localparam int  ANG_W  = ANGLE_BITS + e2q_pkg::ANG_GUARD;
   localparam real ATAN_R = $atan(1.0 / (2.0 ** STEP));
   localparam logic signed [ANG_W-1:0] ATAN_A =
      ANG_W'($rtoi(ATAN_R * (2.0 ** ANGLE_BITS) + 0.5));

   e2q_pkg::data_type         x_in, y_in, xs, ys;
   logic signed [ANG_W-1:0]   h_in;

   always_comb begin
      xs = x_prev >>> STEP;
      ys = y_prev >>> STEP;
      if (!h_prev[ANG_W-1]) begin
         x_in = x_prev - ys;
         y_in = y_prev + xs;
         h_in = h_prev - ATAN_A;
      end else begin
         x_in = x_prev + ys;
         y_in = y_prev - xs;
         h_in = h_prev + ATAN_A;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         h_ff   <= h_in;
         neg_ff <= neg_prev;
      end
   end

endmodule

`default_nettype wire

// ===== src/e2q_sincos.sv =====
// ----------------------------------------------------------------------------
// e2q_sincos
// Half angle, quadrant fold, CORDIC pipeline and cosine sign for one angle.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_sincos #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS   = 16
) (
   input  wire                          clock,
   input  wire [CORDIC_STEPS+1:0]       stage_en,
   input  wire e2q_pkg::angle_in_type   angle_in,
   output e2q_pkg::data_type            cos_ff,
   output e2q_pkg::data_type            sin_ff
);

   localparam int ANG_W   = ANGLE_BITS + e2q_pkg::ANG_GUARD;
   localparam int SHIFT_Q = 60 - ANGLE_BITS;
   localparam logic [63:0] PI_A64 =
      (e2q_pkg::PI_Q60 + (64'd1 << (SHIFT_Q - 1))) >> SHIFT_Q;
   localparam logic [63:0] HPI_A64 =
      ((e2q_pkg::PI_Q60 >> 1) + (64'd1 << (SHIFT_Q - 1))) >> SHIFT_Q;
   localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(PI_A64);
   localparam logic signed [ANG_W-1:0] HPI_A     = ANG_W'(HPI_A64);
   localparam logic signed [ANG_W-1:0] NEG_PI_A  = -PI_A;
   localparam logic signed [ANG_W-1:0] NEG_HPI_A = -HPI_A;

   logic signed [ANG_W-1:0] h_raw, h_in, h0_ff;
   logic                    neg_in, neg0_ff;

   e2q_pkg::data_type       x_pipe   [CORDIC_STEPS+1];
   e2q_pkg::data_type       y_pipe   [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] h_pipe   [CORDIC_STEPS+1];
   logic                    neg_pipe [CORDIC_STEPS+1];

   // half angle at ANGLE_BITS fraction bits
   generate
      if (ANGLE_BITS >= 14) begin : g_up
         assign h_raw = ANG_W'(angle_in) <<< (ANGLE_BITS - 14);
      end else begin : g_down
         assign h_raw = ANG_W'(angle_in >>> (14 - ANGLE_BITS));
      end
   endgenerate

   // fold into [-pi/2, pi/2]; the cosine changes sign, the sine does not
   always_comb begin
      h_in   = h_raw;
      neg_in = 1'b0;
      if (h_raw > HPI_A) begin
         h_in   = PI_A - h_raw;
         neg_in = 1'b1;
      end else if (h_raw < NEG_HPI_A) begin
         h_in   = NEG_PI_A - h_raw;
         neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         h0_ff   <= h_in;
         neg0_ff <= neg_in;
      end
   end

   assign x_pipe[0]   = e2q_pkg::GAIN_Q30;
   assign y_pipe[0]   = '0;
   assign h_pipe[0]   = h0_ff;
   assign neg_pipe[0] = neg0_ff;

   generate
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         e2q_cordic_step #(
            .STEP       (i),
            .ANGLE_BITS (ANGLE_BITS)
         ) u_step (
            .clock    (clock),
            .step_en  (stage_en[i+1]),
            .x_prev   (x_pipe[i]),
            .y_prev   (y_pipe[i]),
            .h_prev   (h_pipe[i]),
            .neg_prev (neg_pipe[i]),
            .x_ff     (x_pipe[i+1]),
            .y_ff     (y_pipe[i+1]),
            .h_ff     (h_pipe[i+1]),
            .neg_ff   (neg_pipe[i+1])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en[CORDIC_STEPS+1]) begin
         cos_ff <= neg_pipe[CORDIC_STEPS] ? -x_pipe[CORDIC_STEPS] : x_pipe[CORDIC_STEPS];
         sin_ff <= y_pipe[CORDIC_STEPS];
      end
   end

endmodule

`default_nettype wire

// ===== src/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// e2q_combine
// ZYX quaternion product network: pair products, rounding, triple products,
// sums, Q1.14 rounding and saturation, one register stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_combine (
   input  wire                               clock,
   input  wire [e2q_pkg::COMB_STAGES-1:0]    stage_en,
   input  wire e2q_pkg::data_type            cr,
   input  wire e2q_pkg::data_type            sr,
   input  wire e2q_pkg::data_type            cp,
   input  wire e2q_pkg::data_type            sp,
   input  wire e2q_pkg::data_type            cy,
   input  wire e2q_pkg::data_type            sy,
   output e2q_pkg::quat_type                 quat_x_ff,
   output e2q_pkg::quat_type                 quat_y_ff,
   output e2q_pkg::quat_type                 quat_z_ff,
   output e2q_pkg::quat_type                 quat_w_ff
);

   localparam e2q_pkg::prod_type HALF_Q30 = 64'sd1 <<< 29;
   localparam e2q_pkg::prod_type HALF_Q46 = 64'sd1 <<< 45;
   localparam logic signed [17:0] SAT_HI  = 18'sd16384;
   localparam logic signed [17:0] SAT_LO  = -18'sd16384;

   function automatic e2q_pkg::data_type round_q30(input e2q_pkg::prod_type p);
      e2q_pkg::prod_type t;
      t = (p + HALF_Q30) >>> 30;
      return t[31:0];
   endfunction

   function automatic e2q_pkg::quat_type to_q14(input e2q_pkg::prod_type s);
      e2q_pkg::prod_type t;
      logic signed [17:0] r;
      t = (s + HALF_Q46) >>> 46;
      r = t[17:0];
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[15:0];
   endfunction

   // signed 32 x 32 product at full width
   function automatic e2q_pkg::prod_type mul_full(input e2q_pkg::data_type a,
                                                  input e2q_pkg::data_type b);
      return e2q_pkg::prod_type'(a) * e2q_pkg::prod_type'(b);
   endfunction

   // stage A: pair products, factors carried along
   e2q_pkg::prod_type pa_cycp_ff, pa_sycr_ff, pa_cycr_ff, pa_sycp_ff;
   e2q_pkg::prod_type pa_crcp_ff, pa_cysr_ff, pa_sysr_ff;
   e2q_pkg::data_type fa_sr_ff, fa_sp_ff, fa_cp_ff, fa_sy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pa_cycp_ff <= mul_full(cy, cp);
         pa_sycr_ff <= mul_full(sy, cr);
         pa_cycr_ff <= mul_full(cy, cr);
         pa_sycp_ff <= mul_full(sy, cp);
         pa_crcp_ff <= mul_full(cr, cp);
         pa_cysr_ff <= mul_full(cy, sr);
         pa_sysr_ff <= mul_full(sy, sr);
         fa_sr_ff   <= sr;
         fa_sp_ff   <= sp;
         fa_cp_ff   <= cp;
         fa_sy_ff   <= sy;
      end
   end

   // stage B: pair products back to Q1.30
   e2q_pkg::data_type rb_cycp_ff, rb_sycr_ff, rb_cycr_ff, rb_sycp_ff;
   e2q_pkg::data_type rb_crcp_ff, rb_cysr_ff, rb_sysr_ff;
   e2q_pkg::data_type fb_sr_ff, fb_sp_ff, fb_cp_ff, fb_sy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rb_cycp_ff <= round_q30(pa_cycp_ff);
         rb_sycr_ff <= round_q30(pa_sycr_ff);
         rb_cycr_ff <= round_q30(pa_cycr_ff);
         rb_sycp_ff <= round_q30(pa_sycp_ff);
         rb_crcp_ff <= round_q30(pa_crcp_ff);
         rb_cysr_ff <= round_q30(pa_cysr_ff);
         rb_sysr_ff <= round_q30(pa_sysr_ff);
         fb_sr_ff   <= fa_sr_ff;
         fb_sp_ff   <= fa_sp_ff;
         fb_cp_ff   <= fa_cp_ff;
         fb_sy_ff   <= fa_sy_ff;
      end
   end

   // stage C: triple products, Q60
   e2q_pkg::prod_type tx_a_ff, tx_b_ff, ty_a_ff, ty_b_ff;
   e2q_pkg::prod_type tz_a_ff, tz_b_ff, tw_a_ff, tw_b_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tx_a_ff <= mul_full(rb_cycp_ff, fb_sr_ff);
         tx_b_ff <= mul_full(rb_sycr_ff, fb_sp_ff);
         ty_a_ff <= mul_full(rb_cycr_ff, fb_sp_ff);
         ty_b_ff <= mul_full(rb_sycp_ff, fb_sr_ff);
         tz_a_ff <= mul_full(rb_crcp_ff, fb_sy_ff);
         tz_b_ff <= mul_full(rb_cysr_ff, fb_sp_ff);
         tw_a_ff <= mul_full(rb_cycr_ff, fb_cp_ff);
         tw_b_ff <= mul_full(rb_sysr_ff, fb_sp_ff);
      end
   end

   // stage D: term sums
   e2q_pkg::prod_type sx_ff, sy_ff, sz_ff, sw_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sx_ff <= tx_a_ff - tx_b_ff;
         sy_ff <= ty_a_ff + ty_b_ff;
         sz_ff <= tz_a_ff - tz_b_ff;
         sw_ff <= tw_a_ff + tw_b_ff;
      end
   end

   // stage E: Q1.14 output register
   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         quat_x_ff <= to_q14(sx_ff);
         quat_y_ff <= to_q14(sy_ff);
         quat_z_ff <= to_q14(sz_ff);
         quat_w_ff <= to_q14(sw_ff);
      end
   end

endmodule

`default_nettype wire
